### rtl/core/cfd_pkg.sv
// Package for the command frame deframer: header constants, field widths,
// the frame phase and result kind types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

   localparam int ByteWidth    = 8;
   localparam int CommandWidth = 16;
   localparam int LengthWidth  = 32;

   localparam logic [ByteWidth-1:0] HdrFirst  = 8'h7F;
   localparam logic [ByteWidth-1:0] HdrSecond = 8'h55;

   typedef logic [ByteWidth-1:0]    byte_type;
   typedef logic [CommandWidth-1:0] command_type;
   typedef logic [LengthWidth-1:0]  length_type;

   typedef enum logic [3:0] {
      PH_HUNT0  = 4'd0,
      PH_HUNT1  = 4'd1,
      PH_CMD_HI = 4'd2,
      PH_CMD_LO = 4'd3,
      PH_LEN0   = 4'd4,
      PH_LEN1   = 4'd5,
      PH_LEN2   = 4'd6,
      PH_LEN3   = 4'd7,
      PH_DATA   = 4'd8,
      PH_TRL0   = 4'd9,
      PH_TRL1   = 4'd10,
      PH_TRL2   = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

endpackage

`default_nettype wire

### rtl/core/cfd_stream_if.sv
// Valid/ready channel interfaces for the deframer: the byte input channel
// and the result channel. Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_req_if;
   import cfd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   import cfd_pkg::*;

   logic        valid;
   logic        ready;
   kind_type    kind;
   byte_type    data_byte;
   command_type command;
   logic        last;

   modport source (output valid, output kind, output data_byte, output command,
                   output last, input ready);
   modport sink (input valid, input kind, input data_byte, input command,
                 input last, output ready);
endinterface

`default_nettype wire

### rtl/core/command_frame_deframer.sv
// Command frame deframer: splits a byte stream into header, command, length,
// payload and trailer, and emits one word per payload byte, empty frame or error.
// Depends on cfd_pkg and the channel interfaces in cfd_stream_if.
//
// Usage: bytes enter on req_chan, one word per ready cycle. A frame is 0x7F 0x55,
// a big-endian 16-bit command, a big-endian 32-bit length, the payload and
// three trailing bytes that are skipped. Each payload byte leaves on rsp_chan
// tagged with the command and a last flag; a zero-length frame gives one
// empty-frame word, and a wrong header byte gives one error word.
// A result word passes through the input register and the result register: the
// edge that accepts its byte loads the input register, and a later edge loads
// the result register, which drives rsp_chan. Throughput is one byte per cycle
// while the receiver keeps up, set by the single pass between the registers.
// Reset (synchronous) returns the parser to hunting for the first header byte
// and empties both registers. When the receiver stalls, the result word holds
// and req_chan.ready falls once the input register is also occupied.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer (
   input wire logic  clock,
   input wire logic  reset,
   cfd_req_if.sink   req_chan,
   cfd_rsp_if.source rsp_chan
);
   import cfd_pkg::*;

   phase_type   phase_ff, phase_in;
   command_type command_ff, command_in;
   length_type  length_ff, length_in;
   logic        s1_valid_ff;
   byte_type    s1_byte_ff;
   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff, out_kind_in;
   byte_type    out_data_ff, out_data_in;
   command_type out_command_ff, out_command_in;
   logic        out_last_ff, out_last_in;

   logic out_free;
   logic s1_move;
   logic process;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_move  = !s1_valid_ff || out_free;
   assign process  = s1_valid_ff && out_free;

   assign req_chan.ready     = s1_move;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_kind_ff;
   assign rsp_chan.data_byte = out_data_ff;
   assign rsp_chan.command   = out_command_ff;
   assign rsp_chan.last      = out_last_ff;

   always_comb begin
      phase_in = phase_ff;
      if (process) begin
         unique case (phase_ff)
            PH_HUNT0:  phase_in = (s1_byte_ff == HdrFirst) ? PH_HUNT1 : PH_HUNT0;
            PH_HUNT1:  phase_in = (s1_byte_ff == HdrSecond) ? PH_CMD_HI : PH_HUNT0;
            PH_CMD_HI: phase_in = PH_CMD_LO;
            PH_CMD_LO: phase_in = PH_LEN0;
            PH_LEN0:   phase_in = PH_LEN1;
            PH_LEN1:   phase_in = PH_LEN2;
            PH_LEN2:   phase_in = PH_LEN3;
            PH_LEN3: begin
               phase_in = ({length_ff[LengthWidth-ByteWidth-1:0], s1_byte_ff} == '0)
                          ? PH_TRL0 : PH_DATA;
            end
            PH_DATA:   phase_in = (length_ff == length_type'(1)) ? PH_TRL0 : PH_DATA;
            PH_TRL0:   phase_in = PH_TRL1;
            PH_TRL1:   phase_in = PH_TRL2;
            PH_TRL2:   phase_in = PH_HUNT0;
            default:   phase_in = (s1_byte_ff == HdrFirst) ? PH_HUNT1 : PH_HUNT0;
         endcase
      end
   end

   always_comb begin
      command_in     = command_ff;
      length_in      = length_ff;
      out_valid_in   = out_valid_ff;
      out_kind_in    = out_kind_ff;
      out_data_in    = out_data_ff;
      out_command_in = out_command_ff;
      out_last_in    = out_last_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (process) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (s1_byte_ff != HdrSecond) begin
                  out_valid_in   = 1'b1;
                  out_kind_in    = KIND_ERROR;
                  out_data_in    = '0;
                  out_command_in = '0;
                  out_last_in    = 1'b0;
               end
            end
            PH_CMD_HI: command_in = {s1_byte_ff, command_ff[ByteWidth-1:0]};
            PH_CMD_LO: command_in = {command_ff[CommandWidth-1:ByteWidth], s1_byte_ff};
            PH_LEN0, PH_LEN1, PH_LEN2: begin
               length_in = {length_ff[LengthWidth-ByteWidth-1:0], s1_byte_ff};
            end
            PH_LEN3: begin
               length_in = {length_ff[LengthWidth-ByteWidth-1:0], s1_byte_ff};
               if (length_in == '0) begin
                  out_valid_in   = 1'b1;
                  out_kind_in    = KIND_EMPTY;
                  out_data_in    = '0;
                  out_command_in = command_ff;
                  out_last_in    = 1'b1;
               end
            end
            PH_DATA: begin
               length_in      = length_ff - length_type'(1);
               out_valid_in   = 1'b1;
               out_kind_in    = KIND_DATA;
               out_data_in    = s1_byte_ff;
               out_command_in = command_ff;
               out_last_in    = (length_ff == length_type'(1));
            end
            PH_TRL0, PH_TRL1, PH_TRL2: begin
               out_valid_in = 1'b0;
            end
            default: begin
               if (s1_byte_ff != HdrFirst) begin
                  out_valid_in   = 1'b1;
                  out_kind_in    = KIND_ERROR;
                  out_data_in    = '0;
                  out_command_in = '0;
                  out_last_in    = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT0;
         command_ff   <= '0;
         length_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            s1_valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_byte_ff <= req_chan.rx_byte;
      end
      out_kind_ff    <= out_kind_in;
      out_data_ff    <= out_data_in;
      out_command_ff <= out_command_in;
      out_last_ff    <= out_last_in;
   end

endmodule

`default_nettype wire

### tb/command_frame_deframer_tb.sv
// Self-checking testbench for command_frame_deframer: a directed table, then random
// frames and noise with random idling on both channels, checked word by word.
// Depends on cfd_pkg, the channel interfaces in cfd_stream_if and the deframer RTL.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer_tb;
   import cfd_pkg::*;

   localparam int HalfPeriod     = 2;
   localparam int ResetCycles    = 5;
   localparam int RandomBytes    = 900;
   localparam int QuietTail      = 150;
   localparam int LongHoldCycles = 60;
   localparam int WatchdogLimit  = 2000;
   localparam int DrainCycles    = 8;
   localparam bit Typed          = 1'b1;
   localparam bit Predicted      = 1'b0;

   typedef struct packed {
      kind_type    kind;
      byte_type    data_byte;
      command_type command;
      logic        last;
   } frame_word_type;

   typedef struct {
      byte_type       rx_byte;
      bit             typed;
      bit             has_word;
      frame_word_type word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   cfd_req_if req_chan ();
   cfd_rsp_if rsp_chan ();

   command_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   phase_type      parse_phase = PH_HUNT0;
   command_type    parse_command = '0;
   length_type     parse_remaining = '0;
   frame_word_type expected_words[$];
   stim_row_type   directed_rows[$];
   int             errors = 0;
   int             quiet_cycles = 0;
   int             bytes_sent = 0;
   bit             sender_idles = 1'b1;
   bit             receiver_idles = 1'b1;
   int             holds_requested = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             stall_left = 0;

   always #HalfPeriod clock = ~clock;

   function automatic bit parse_frame_byte(input byte_type b, output frame_word_type w);
      bit has = 1'b0;
      w.kind = KIND_DATA;
      w.data_byte = '0;
      w.command = '0;
      w.last = 1'b0;
      case (parse_phase)
         PH_HUNT1: begin
            if (b == HdrSecond) begin
               parse_phase = PH_CMD_HI;
            end else begin
               w.kind = KIND_ERROR;
               has = 1'b1;
               parse_phase = PH_HUNT0;
            end
         end
         PH_CMD_HI: begin
            parse_command[15:8] = b;
            parse_phase = PH_CMD_LO;
         end
         PH_CMD_LO: begin
            parse_command[7:0] = b;
            parse_phase = PH_LEN0;
         end
         PH_LEN0, PH_LEN1, PH_LEN2: begin
            parse_remaining = {parse_remaining[23:0], b};
            parse_phase = phase_type'(parse_phase + 4'd1);
         end
         PH_LEN3: begin
            parse_remaining = {parse_remaining[23:0], b};
            if (parse_remaining == '0) begin
               w.kind = KIND_EMPTY;
               w.command = parse_command;
               w.last = 1'b1;
               has = 1'b1;
               parse_phase = PH_TRL0;
            end else begin
               parse_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            parse_remaining = parse_remaining - length_type'(1);
            w.kind = KIND_DATA;
            w.data_byte = b;
            w.command = parse_command;
            w.last = (parse_remaining == '0);
            has = 1'b1;
            if (w.last) begin
               parse_phase = PH_TRL0;
            end
         end
         PH_TRL0, PH_TRL1: begin
            parse_phase = phase_type'(parse_phase + 4'd1);
         end
         PH_TRL2: begin
            parse_phase = PH_HUNT0;
         end
         default: begin
            if (b == HdrFirst) begin
               parse_phase = PH_HUNT1;
            end else begin
               w.kind = KIND_ERROR;
               has = 1'b1;
               parse_phase = PH_HUNT0;
            end
         end
      endcase
      return has;
   endfunction

   task automatic add_row(input byte_type b, input bit typed, input bit has_word,
                          input kind_type kind, input byte_type data_byte,
                          input command_type command, input logic last);
      stim_row_type row;
      row.rx_byte = b;
      row.typed = typed;
      row.has_word = has_word;
      row.word.kind = kind;
      row.word.data_byte = data_byte;
      row.word.command = command;
      row.word.last = last;
      directed_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_byte(input byte_type b, input bit typed, input bit typed_has,
                            input frame_word_type typed_word);
      frame_word_type w;
      bit has;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      has = parse_frame_byte(b, w);
      if (typed) begin
         has = typed_has;
         w = typed_word;
      end
      if (has) begin
         expected_words.push_back(w);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_random(input byte_type b);
      send_byte(b, Predicted, 1'b0, frame_word_type'(0));
   endtask

   task automatic send_frame(input int unsigned len, input bit with_hold);
      command_type command;
      length_type  frame_len;
      command = command_type'($urandom);
      frame_len = len;
      send_random(HdrFirst);
      send_random(HdrSecond);
      send_random(command[15:8]);
      send_random(command[7:0]);
      for (int i = 3; i >= 0; i--) begin
         send_random(frame_len[8*i +: 8]);
      end
      if (with_hold) begin
         holds_requested <= holds_requested + 1;
      end
      for (int unsigned i = 0; i < len; i++) begin
         send_random(byte_type'($urandom));
      end
      repeat (3) begin
         send_random(($urandom_range(0, 3) == 0) ? HdrFirst : byte_type'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (holds_requested != holds_served) begin
         holds_served++;
         hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_word_type want;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d, data_byte %h, command %h, last %0d",
                   rsp_chan.kind, rsp_chan.data_byte, rsp_chan.command, rsp_chan.last);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_chan.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_chan.kind);
               errors++;
            end
            if (rsp_chan.data_byte !== want.data_byte) begin
               $error("data_byte: expected %h, got %h", want.data_byte, rsp_chan.data_byte);
               errors++;
            end
            if (rsp_chan.command !== want.command) begin
               $error("command: expected %h, got %h", want.command, rsp_chan.command);
               errors++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_chan.last);
               errors++;
            end
         end
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned len;
      int          frames;
      int          random_start;
      byte_type    b;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready = 1'b0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;

      // Header errors, including a second byte that is not retried as a first one.
      add_row(8'h00, Typed, 1'b1, KIND_ERROR, 8'h00, 16'h0000, 1'b0);
      add_row(HdrFirst, Typed, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(HdrFirst, Typed, 1'b1, KIND_ERROR, 8'h00, 16'h0000, 1'b0);
      add_row(HdrSecond, Typed, 1'b1, KIND_ERROR, 8'h00, 16'h0000, 1'b0);
      // Empty frame with the largest command, and trailing bytes that look like a header.
      add_row(HdrFirst, Typed, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(HdrSecond, Typed, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'hFF, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'hFF, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Typed, 1'b1, KIND_EMPTY, 8'h00, 16'hFFFF, 1'b1);
      add_row(HdrFirst, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(HdrSecond, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'hFF, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      // One-byte frame with the smallest command and the largest payload byte.
      add_row(HdrFirst, Typed, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(HdrSecond, Typed, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h01, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'hFF, Typed, 1'b1, KIND_DATA, 8'hFF, 16'h0000, 1'b1);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);
      add_row(8'h00, Predicted, 1'b0, KIND_DATA, 8'h00, 16'h0000, 1'b0);

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                   directed_rows[i].has_word, directed_rows[i].word);
      end

      // Mostly well-formed frames; the rest is stray bytes and broken headers.
      frames = 0;
      random_start = bytes_sent;
      while (bytes_sent - random_start < RandomBytes) begin
         sender_idles = (bytes_sent - random_start) < (RandomBytes - QuietTail);
         receiver_idles <= sender_idles;
         case ($urandom_range(0, 9))
            0: begin
               b = byte_type'($urandom);
               send_random(b);
               if (b == HdrFirst) begin
                  b = byte_type'($urandom);
                  send_random((b == HdrSecond) ? ~b : b);
               end
            end
            1: begin
               send_random(HdrFirst);
               b = byte_type'($urandom);
               send_random((b == HdrSecond) ? ~b : b);
            end
            default: begin
               frames++;
               if (frames == 3) begin
                  len = $urandom_range(256, 300);
               end else if ($urandom_range(0, 7) == 0) begin
                  len = 0;
               end else begin
                  len = $urandom_range(1, 12);
               end
               send_frame(len, frames == 3 || frames == 20);
            end
         endcase
      end
      req_chan.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
